>>> rtl/core/lcdmlt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD mode/line timing package
// Shared types and constants for the scan-line timing sequencer.
// ----------------------------------------------------------------------------
package lcdmlt_pkg;

	// default timing parameters
	localparam int LINE_CLOCKS_DEF     = 456;
	localparam int LINES_PER_FRAME_DEF = 155;
	localparam int VISIBLE_LINES_DEF   = 144;

	// phase exit points within a line
	localparam logic [9:0] OAM_END_CLK  = 10'd80;
	localparam logic [9:0] XFER_END_CLK = 10'd252;
	localparam logic [9:0] CLOCK_MAX    = 10'h3FF;

	// STAT mode codes
	localparam logic [1:0] MODE_HBLANK = 2'd0;
	localparam logic [1:0] MODE_VBLANK = 2'd1;
	localparam logic [1:0] MODE_OAM    = 2'd2;
	localparam logic [1:0] MODE_XFER   = 2'd3;

	typedef enum logic [5:0] {
		PH_OAM     = 6'b000001,
		PH_XFER    = 6'b000010,
		PH_HBLANK  = 6'b000100,
		PH_DONE    = 6'b001000,
		PH_VBENTRY = 6'b010000,
		PH_VBLANK  = 6'b100000
	} phase_t;

	typedef enum logic [2:0] {
		REG_LINE_COMPARE   = 3'd0,
		REG_HBLANK_IRQ_EN  = 3'd1,
		REG_VBLANK_IRQ_EN  = 3'd2,
		REG_OAM_IRQ_EN     = 3'd3,
		REG_COINC_IRQ_EN   = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] line_compare;
		logic       hblank_irq_enable;
		logic       vblank_status_irq_enable;
		logic       oam_irq_enable;
		logic       coincidence_irq_enable;
	} lcd_cfg_t;

	typedef struct packed {
		phase_t     phase;
		logic [9:0] line_clock;
		logic [7:0] line_counter;
		logic       ef_hblank;
		logic       ef_oam;
		logic       ef_xfer;
		logic       acc_oam;
		logic       acc_vram;
		logic [1:0] stat_bits;
	} lcd_state_t;

	typedef struct packed {
		logic [1:0] stat_mode;
		logic [7:0] line_number;
		logic       coincidence_set;
		logic       status_irq;
		logic       vblank_irq;
		logic       render_line;
		logic       frame_ready;
		logic       oam_access;
		logic       vram_access;
	} lcd_result_t;

endpackage

>>> rtl/core/lcdmlt_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD timing step
// Next-state and result logic for one clock-count request: saturating line
// clock add, at most one phase transition, entry actions and irq requests.
// ----------------------------------------------------------------------------
module lcdmlt_step #(
	parameter int LINE_CLOCKS     = lcdmlt_pkg::LINE_CLOCKS_DEF,
	parameter int LINES_PER_FRAME = lcdmlt_pkg::LINES_PER_FRAME_DEF,
	parameter int VISIBLE_LINES   = lcdmlt_pkg::VISIBLE_LINES_DEF
) (
	input  lcdmlt_pkg::lcd_state_t  cur,
	input  lcdmlt_pkg::lcd_cfg_t    cfg,
	input  logic [7:0]              elapsed_clocks,
	output lcdmlt_pkg::lcd_state_t  nxt,
	output lcdmlt_pkg::lcd_result_t res
);
	import lcdmlt_pkg::*;

	localparam logic [9:0] LINE_END  = 10'(LINE_CLOCKS);
	localparam logic [8:0] VIS_LINE9 = 9'(VISIBLE_LINES);
	localparam logic [8:0] LPF_LINE9 = 9'(LINES_PER_FRAME);
	localparam logic [7:0] VIS_LINE8 = 8'(VISIBLE_LINES);
	// line after line VISIBLE_LINES, taken modulo the frame length
	localparam logic [7:0] FIRST_VB_LINE = 8'((VISIBLE_LINES + 1) % LINES_PER_FRAME);

	logic [10:0] sum;
	logic [9:0]  t;
	logic [8:0]  next_line;
	logic [7:0]  vb_line;
	logic        coin;
	logic        sirq;
	logic        virq;
	logic        render;
	logic        ready;

	assign sum       = {1'b0, cur.line_clock} + {3'b000, elapsed_clocks};
	assign t         = sum[10] ? CLOCK_MAX : sum[9:0];
	assign next_line = {1'b0, cur.line_counter} + 9'd1;
	// in V-blank the counter is either VISIBLE_LINES (the first V-blank line) or already below
	// the frame length, so no general modulo is needed
	assign vb_line   = (cur.line_counter == VIS_LINE8) ? FIRST_VB_LINE :
		(next_line == LPF_LINE9) ? 8'd0 : next_line[7:0];

	always_comb begin
		nxt            = cur;
		nxt.line_clock = t;
		coin           = 1'b0;
		sirq           = 1'b0;
		virq           = 1'b0;
		render         = 1'b0;
		ready          = 1'b0;
		unique case (cur.phase)
			PH_XFER: begin
				if (!cur.ef_xfer) begin
					nxt.stat_bits = MODE_XFER;
					nxt.acc_oam   = 1'b1;
					nxt.acc_vram  = 1'b1;
					nxt.ef_xfer   = 1'b1;
					nxt.ef_oam    = 1'b0;
					render        = 1'b1;
				end
				if (t > XFER_END_CLK)
					nxt.phase = PH_HBLANK;
			end
			PH_HBLANK: begin
				if (!cur.ef_hblank) begin
					sirq          = cfg.hblank_irq_enable;
					nxt.stat_bits = MODE_HBLANK;
					nxt.acc_oam   = 1'b0;
					nxt.acc_vram  = 1'b1;
					nxt.ef_hblank = 1'b1;
					nxt.ef_xfer   = 1'b0;
				end
				if (t > LINE_END)
					nxt.phase = PH_DONE;
			end
			PH_DONE: begin
				nxt.line_clock   = 10'd0;
				nxt.ef_hblank    = 1'b0;
				nxt.line_counter = next_line[7:0];
				coin = cfg.coincidence_irq_enable &&
					(next_line == {1'b0, cfg.line_compare});
				sirq = coin;
				nxt.phase = (next_line == VIS_LINE9) ? PH_VBENTRY : PH_OAM;
			end
			PH_VBENTRY: begin
				virq          = 1'b1;
				sirq          = cfg.vblank_status_irq_enable;
				nxt.stat_bits = MODE_VBLANK;
				nxt.acc_oam   = 1'b1;
				nxt.acc_vram  = 1'b1;
				ready         = 1'b1;
				nxt.phase     = PH_VBLANK;
			end
			PH_VBLANK: begin
				if (t >= LINE_END) begin
					nxt.line_clock   = 10'd0;
					nxt.line_counter = vb_line;
					coin = cfg.coincidence_irq_enable && (vb_line == cfg.line_compare);
					sirq = coin;
					if (next_line == LPF_LINE9)
						nxt.phase = PH_OAM;
				end
			end
			default: begin
				// OAM search; stray codes fall in here as well
				nxt.phase = PH_OAM;
				if (!cur.ef_oam) begin
					sirq          = cfg.oam_irq_enable;
					nxt.stat_bits = MODE_OAM;
					nxt.acc_oam   = 1'b0;
					nxt.acc_vram  = 1'b1;
					nxt.ef_oam    = 1'b1;
					nxt.ef_hblank = 1'b0;
				end
				if (t > OAM_END_CLK)
					nxt.phase = PH_XFER;
			end
		endcase
	end

	always_comb begin
		res.stat_mode       = nxt.stat_bits;
		res.line_number     = nxt.line_counter;
		res.coincidence_set = coin;
		res.status_irq      = sirq;
		res.vblank_irq      = virq;
		res.render_line     = render;
		res.frame_ready     = ready;
		res.oam_access      = nxt.acc_oam;
		res.vram_access     = nxt.acc_vram;
	end

endmodule

>>> rtl/core/lcd_mode_line_timing_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD mode/line timing unit
// Steps the LCD scan-line sequencer by the elapsed_clocks value of each request and
// reports STAT mode, LY, coincidence, interrupt requests and access flags.
// ----------------------------------------------------------------------------
//  channel   signals                                        direction
//  item      item_valid, item_stall, elapsed_clocks         in
//  result    result_valid, result_stall, stat_mode ...      out
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data      in
//
//  One request per cycle unless the result stalls. A request goes through the
//  input register, then one pass of step logic into the result register and
//  the state. The line state feeds back through lcdmlt_step.
//  A stalled result holds; one more request waits in the input register.
//  arst_n clears state to OAM search, line 0, both access flags set.
//  Config writes are always ready and take effect on the next step.
// ----------------------------------------------------------------------------
module lcd_mode_line_timing_unit #(
	parameter int LINE_CLOCKS     = lcdmlt_pkg::LINE_CLOCKS_DEF,
	parameter int LINES_PER_FRAME = lcdmlt_pkg::LINES_PER_FRAME_DEF,
	parameter int VISIBLE_LINES   = lcdmlt_pkg::VISIBLE_LINES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,

	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data,

	input  logic       item_valid,
	output logic       item_stall,
	input  logic [7:0] elapsed_clocks,

	output logic       result_valid,
	input  logic       result_stall,
	output logic [1:0] stat_mode,
	output logic [7:0] line_number,
	output logic       coincidence_set,
	output logic       status_irq,
	output logic       vblank_irq,
	output logic       render_line,
	output logic       frame_ready,
	output logic       oam_access,
	output logic       vram_access
);
	import lcdmlt_pkg::*;

	localparam lcd_state_t STATE_RESET = '{
		phase:        PH_OAM,
		line_clock:   10'd0,
		line_counter: 8'd0,
		ef_hblank:    1'b0,
		ef_oam:       1'b0,
		ef_xfer:      1'b0,
		acc_oam:      1'b1,
		acc_vram:     1'b1,
		stat_bits:    MODE_HBLANK
	};

	lcd_cfg_t    cfg_q;
	lcd_state_t  state_q;
	lcd_state_t  state_nxt;
	lcd_result_t step_res;
	lcd_result_t res_q;
	logic        valid_s1;
	logic [7:0]  elapsed_s1;
	logic        result_valid_q;
	logic        advance;
	logic        accept;

	assign cfg_ready  = 1'b1;
	assign advance    = valid_s1 && (!result_valid_q || !result_stall);
	assign item_stall = valid_s1 && !advance;
	assign accept     = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_LINE_COMPARE:  cfg_q.line_compare             <= cfg_data;
				REG_HBLANK_IRQ_EN: cfg_q.hblank_irq_enable        <= cfg_data[0];
				REG_VBLANK_IRQ_EN: cfg_q.vblank_status_irq_enable <= cfg_data[0];
				REG_OAM_IRQ_EN:    cfg_q.oam_irq_enable           <= cfg_data[0];
				REG_COINC_IRQ_EN:  cfg_q.coincidence_irq_enable   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			elapsed_s1 <= elapsed_clocks;
	end

	lcdmlt_step #(
		.LINE_CLOCKS     (LINE_CLOCKS),
		.LINES_PER_FRAME (LINES_PER_FRAME),
		.VISIBLE_LINES   (VISIBLE_LINES)
	) u_step (
		.cur            (state_q),
		.cfg            (cfg_q),
		.elapsed_clocks (elapsed_s1),
		.nxt            (state_nxt),
		.res            (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q              <= STATE_RESET;
			result_valid_q       <= 1'b0;
		end else if (advance) begin
			state_q              <= state_nxt;
			result_valid_q       <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q       <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_q <= step_res;
	end

	assign result_valid    = result_valid_q;
	assign stat_mode       = res_q.stat_mode;
	assign line_number     = res_q.line_number;
	assign coincidence_set = res_q.coincidence_set;
	assign status_irq      = res_q.status_irq;
	assign vblank_irq      = res_q.vblank_irq;
	assign render_line     = res_q.render_line;
	assign frame_ready     = res_q.frame_ready;
	assign oam_access      = res_q.oam_access;
	assign vram_access     = res_q.vram_access;

`ifndef SYNTHESIS
	a_stall_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1)
		else $error("input stalled with empty input register");

	a_frame_ready_vblank: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && frame_ready |-> vblank_irq && stat_mode == MODE_VBLANK)
		else $error("frame_ready without V-blank entry");

	a_render_in_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && render_line |-> stat_mode == MODE_XFER && oam_access && vram_access)
		else $error("render request outside transfer entry");

	a_coinc_irq: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && coincidence_set |-> status_irq && cfg_q.coincidence_irq_enable)
		else $error("coincidence without status irq");

	a_line_advance: assert property (@(posedge clk) disable iff (!arst_n)
		advance && state_q.phase == PH_DONE |=> state_q.line_clock == 10'd0)
		else $error("line clock not cleared at line end");
`endif

endmodule

>>> dv/lcdmlt_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD mode/line timing checker
// Tracks the scan-line sequencer for every accepted request and compares each
// returned result, field by field, against the oldest pending expectation.
// ----------------------------------------------------------------------------
package lcdmlt_tb_pkg;
	import lcdmlt_pkg::*;

	class mode_line_checker;
		// register copy
		logic [7:0] lyc;
		logic       hblank_en;
		logic       vblank_en;
		logic       oam_en;
		logic       coinc_en;

		// sequencer copy
		logic [9:0] line_clk;
		phase_t     ph;
		logic [7:0] line_cnt;
		logic       ent_hblank;
		logic       ent_oam;
		logic       ent_xfer;
		logic       acc_oam;
		logic       acc_vram;
		logic [1:0] stat;

		lcd_result_t due_results[$];
		int unsigned mismatches;
		int unsigned results_seen;

		function new();
			lyc = '0;
			hblank_en = 1'b0;
			vblank_en = 1'b0;
			oam_en = 1'b0;
			coinc_en = 1'b0;
			line_clk = '0;
			ph = PH_OAM;
			line_cnt = '0;
			ent_hblank = 1'b0;
			ent_oam = 1'b0;
			ent_xfer = 1'b0;
			acc_oam = 1'b1;
			acc_vram = 1'b1;
			stat = MODE_HBLANK;
			mismatches = 0;
			results_seen = 0;
		endfunction

		function void apply_reg(cfg_reg_t idx, logic [7:0] data);
			case (idx)
				REG_LINE_COMPARE:  lyc = data;
				REG_HBLANK_IRQ_EN: hblank_en = data[0];
				REG_VBLANK_IRQ_EN: vblank_en = data[0];
				REG_OAM_IRQ_EN:    oam_en = data[0];
				REG_COINC_IRQ_EN:  coinc_en = data[0];
				default: ;
			endcase
		endfunction

		// one sequencer step: add clocks, at most one phase transition
		function lcd_result_t step_sequencer(logic [7:0] clocks);
			lcd_result_t r;
			logic [10:0] t;
			logic [8:0] next;
			r = '0;
			t = {1'b0, line_clk} + {3'b000, clocks};
			if (t > {1'b0, CLOCK_MAX})
				t = {1'b0, CLOCK_MAX};
			line_clk = t[9:0];
			case (ph)
				PH_XFER: begin
					if (!ent_xfer) begin
						stat = MODE_XFER;
						acc_oam = 1'b1;
						acc_vram = 1'b1;
						ent_xfer = 1'b1;
						ent_oam = 1'b0;
						r.render_line = 1'b1;
					end
					if (t > {1'b0, XFER_END_CLK})
						ph = PH_HBLANK;
				end
				PH_HBLANK: begin
					if (!ent_hblank) begin
						if (hblank_en)
							r.status_irq = 1'b1;
						stat = MODE_HBLANK;
						acc_oam = 1'b0;
						acc_vram = 1'b1;
						ent_hblank = 1'b1;
						ent_xfer = 1'b0;
					end
					if (t > LINE_CLOCKS_DEF)
						ph = PH_DONE;
				end
				PH_DONE: begin
					line_clk = '0;
					ent_hblank = 1'b0;
					next = {1'b0, line_cnt} + 9'd1;
					line_cnt = next[7:0];
					// compared on the unwrapped count
					if (next == {1'b0, lyc} && coinc_en) begin
						r.coincidence_set = 1'b1;
						r.status_irq = 1'b1;
					end
					ph = (next == VISIBLE_LINES_DEF) ? PH_VBENTRY : PH_OAM;
				end
				PH_VBENTRY: begin
					r.vblank_irq = 1'b1;
					if (vblank_en)
						r.status_irq = 1'b1;
					stat = MODE_VBLANK;
					acc_oam = 1'b1;
					acc_vram = 1'b1;
					r.frame_ready = 1'b1;
					ph = PH_VBLANK;
				end
				PH_VBLANK: begin
					if (t >= LINE_CLOCKS_DEF) begin
						line_clk = '0;
						next = {1'b0, line_cnt} + 9'd1;
						line_cnt = 8'(next % LINES_PER_FRAME_DEF);
						if (line_cnt == lyc && coinc_en) begin
							r.coincidence_set = 1'b1;
							r.status_irq = 1'b1;
						end
						if (next == LINES_PER_FRAME_DEF)
							ph = PH_OAM;
					end
				end
				default: begin
					ph = PH_OAM;
					if (!ent_oam) begin
						if (oam_en)
							r.status_irq = 1'b1;
						stat = MODE_OAM;
						acc_oam = 1'b0;
						acc_vram = 1'b1;
						ent_oam = 1'b1;
						ent_hblank = 1'b0;
					end
					if (t > {1'b0, OAM_END_CLK})
						ph = PH_XFER;
				end
			endcase
			r.stat_mode = stat;
			r.line_number = line_cnt;
			r.oam_access = acc_oam;
			r.vram_access = acc_vram;
			return r;
		endfunction

		function void note_request(logic [7:0] clocks);
			due_results.push_back(step_sequencer(clocks));
		endfunction

		function void compare_field(string fname, int unsigned want, int unsigned got);
			if (want != got) begin
				mismatches++;
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
			end
		endfunction

		function void check_result(lcd_result_t got);
			lcd_result_t want;
			results_seen++;
			if (due_results.size() == 0) begin
				mismatches++;
				$display("%0t: result with no request pending, expected none, actual %h",
					$time, got);
				return;
			end
			want = due_results[0];
			due_results.delete(0);
			compare_field("stat_mode", want.stat_mode, got.stat_mode);
			compare_field("line_number", want.line_number, got.line_number);
			compare_field("coincidence_set", want.coincidence_set, got.coincidence_set);
			compare_field("status_irq", want.status_irq, got.status_irq);
			compare_field("vblank_irq", want.vblank_irq, got.vblank_irq);
			compare_field("render_line", want.render_line, got.render_line);
			compare_field("frame_ready", want.frame_ready, got.frame_ready);
			compare_field("oam_access", want.oam_access, got.oam_access);
			compare_field("vram_access", want.vram_access, got.vram_access);
		endfunction

		function int unsigned pending();
			return due_results.size();
		endfunction
	endclass

endpackage

>>> dv/tb_lcd_mode_line_timing_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD mode/line timing unit testbench
// Drives clock-count requests with random gaps and result stalls, programs the
// LYC and interrupt enables between phases, and checks every result.
// ----------------------------------------------------------------------------
module tb_lcd_mode_line_timing_unit;
	import lcdmlt_pkg::*;
	import lcdmlt_tb_pkg::*;

	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 240;
	localparam int HOLD_CYCLES = 60;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;
	logic       item_valid = 1'b0;
	logic       item_stall;
	logic [7:0] elapsed_clocks = '0;
	logic       result_valid;
	logic       result_stall = 1'b0;
	lcd_result_t seen;

	bit          calm = 1'b0;
	int unsigned hold_left = 0;
	int unsigned hold_mark = 0;
	int unsigned hold_points[2] = '{400, 1300};

	mode_line_checker chk;

	lcd_mode_line_timing_unit dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.item_valid      (item_valid),
		.item_stall      (item_stall),
		.elapsed_clocks  (elapsed_clocks),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.stat_mode       (seen.stat_mode),
		.line_number     (seen.line_number),
		.coincidence_set (seen.coincidence_set),
		.status_irq      (seen.status_irq),
		.vblank_irq      (seen.vblank_irq),
		.render_line     (seen.render_line),
		.frame_ready     (seen.frame_ready),
		.oam_access      (seen.oam_access),
		.vram_access     (seen.vram_access)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// receiver: random stalls, plus long hold-offs so the input side backs up
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else if (hold_mark < 2 && chk != null && chk.results_seen >= hold_points[hold_mark]) begin
			hold_left = HOLD_CYCLES;
			hold_mark++;
			result_stall <= 1'b1;
		end else if (calm) begin
			result_stall <= 1'b0;
		end else begin
			result_stall <= ($urandom_range(0, 99) < 15);
		end
	end

	// inputs change only at rising edges, so the falling edge shows what the next
	// rising edge will take
	always @(negedge clk) begin
		if (arst_n && result_valid && !result_stall)
			chk.check_result(seen);
	end

	task automatic write_reg(cfg_reg_t idx, logic [7:0] data);
		bit fire;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do begin
			@(negedge clk);
			fire = cfg_ready;
			@(posedge clk);
		end while (!fire);
		chk.apply_reg(idx, data);
	endtask

	task automatic program_regs(logic [7:0] lyc, bit h_en, bit v_en, bit o_en, bit c_en);
		write_reg(REG_LINE_COMPARE, lyc);
		write_reg(REG_HBLANK_IRQ_EN, {7'd0, h_en});
		write_reg(REG_VBLANK_IRQ_EN, {7'd0, v_en});
		write_reg(REG_OAM_IRQ_EN, {7'd0, o_en});
		write_reg(REG_COINC_IRQ_EN, {7'd0, c_en});
		cfg_valid <= 1'b0;
	endtask

	task automatic offer_clocks(logic [7:0] clocks);
		bit fire;
		if (!calm && $urandom_range(0, 99) < 15) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		item_valid <= 1'b1;
		elapsed_clocks <= clocks;
		do begin
			@(negedge clk);
			fire = !item_stall;
			@(posedge clk);
		end while (!fire);
		chk.note_request(clocks);
	endtask

	// mostly large steps so that many frames are covered
	function automatic logic [7:0] pick_clocks();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 8'($urandom_range(160, 255));
		else if (r < 75)
			return 8'hFF;
		else if (r < 90)
			return 8'($urandom_range(0, 31));
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic drain();
		while (chk.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		// line 0 ends with a saturated clock; then each exit point is hit exactly
		logic [7:0] opening[20] = '{8'd0, 8'd80, 8'd255, 8'd255, 8'd255, 8'd255,
			8'd1, 8'd80, 8'd0, 8'd171, 8'd1, 8'd203, 8'd1, 8'd0,
			8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 8'd128};
		logic [7:0] lyc;
		chk = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		program_regs(8'd1, 1'b1, 1'b1, 1'b1, 1'b1);
		foreach (opening[i])
			offer_clocks(opening[i]);
		item_valid <= 1'b0;
		for (int p = 0; p < PHASES; p++) begin
			drain();
			case (p)
				0: program_regs(8'd0, 1'b1, 1'b1, 1'b1, 1'b1);
				1: program_regs(8'd255, 1'b0, 1'b0, 1'b0, 1'b0);
				2: program_regs(8'd144, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), 1'b1);
				3: program_regs(8'd154, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), 1'b1);
				4: begin
					// matching line with the coincidence interrupt off
					lyc = 8'($urandom_range(0, 154));
					program_regs(lyc, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)), 1'b0);
				end
				default: begin
					lyc = 8'($urandom_range(0, 255));
					program_regs(lyc, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				calm <= (p == 3 && n < 150);
				offer_clocks(pick_clocks());
			end
			item_valid <= 1'b0;
		end
		calm <= 1'b0;
		drain();
		repeat (8) @(posedge clk);
		if (chk.mismatches == 0 && chk.pending() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#2000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
